// ===== rtl/mse_pkg.sv =====
`timescale 1ns / 1ps

package mse_pkg;

   // register file geometry
   localparam int REG_COUNT = 32;
   localparam int REG_ADDR_W = 5;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'b000000;
   localparam logic [5:0] OP_J       = 6'b000010;
   localparam logic [5:0] OP_BNE     = 6'b000101;
   localparam logic [5:0] OP_ADDI    = 6'b001000;
   localparam logic [5:0] OP_ADDIU   = 6'b001001;
   localparam logic [5:0] OP_ORI     = 6'b001101;
   localparam logic [5:0] OP_LUI     = 6'b001111;
   localparam logic [5:0] OP_COP0    = 6'b010000;
   localparam logic [5:0] OP_LW      = 6'b100011;
   localparam logic [5:0] OP_SW      = 6'b101011;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL = 6'b000000;
   localparam logic [5:0] FN_OR  = 6'b100101;

   // cop0 move-to code in the rs field, and the status register index
   localparam logic [4:0] COP_MT      = 5'b00100;
   localparam logic [4:0] COP0_STATUS = 5'd12;

   // status word bit that isolates the cache
   localparam int ISOLATE_BIT = 16;

   // jump keeps the top nibble of pc + 4
   localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;

   // memory request kinds
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // result status codes
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_BAD_OP   = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_ISOLATED = 3'd3;
   localparam logic [2:0] ST_BAD_COP0 = 3'd4;

   // request beat kinds
   localparam logic REQ_INSTR = 1'b0;
   localparam logic REQ_LOAD  = 1'b1;

endpackage

// ===== rtl/mse_req_if.sv =====
`timescale 1ns / 1ps

interface mse_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] instr_word;
   logic [31:0] load_data;

   modport source (output valid, output req_type, output instr_word, output load_data,
                   input ready);
   modport sink (input valid, input req_type, input instr_word, input load_data,
                 output ready);
endinterface

// ===== rtl/mse_rsp_if.sv =====
`timescale 1ns / 1ps

interface mse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic [1:0]  mem_kind;
   logic [31:0] mem_address;
   logic [31:0] mem_write_data;
   logic [2:0]  status;

   modport source (output valid, output next_pc, output mem_kind, output mem_address,
                   output mem_write_data, output status, input ready);
   modport sink (input valid, input next_pc, input mem_kind, input mem_address,
                 input mem_write_data, input status, output ready);
endinterface

// ===== rtl/mips_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// MIPS subset execute unit (SLL, OR, J, BNE, ADDI, ADDIU, LUI, ORI, MTC0, LW, SW).
// req_bus carries one beat per item: an instruction word fetched at the current pc
// (req_type 0) or the data word returned for the pending LW (req_type 1).
// rsp_bus returns exactly one beat per request: next fetch address, memory request
// (kind, address, write data) and a status code.
// A request is captured in the operand register stage, then executed into the
// response register. Throughput: one beat per cycle while rsp ready stays high; the
// register file is read as the request is taken and results written as the item
// leaves the operand stage, with a bypass from that write port into the read.
// The caller must fetch at rsp next_pc; a load beat reports the unchanged pc.
// Reset: pc goes to START_PC, isolation and pending load clear, and all 32
// registers read as zero at once through per-register valid bits.
// Stall: while rsp ready is low the response register holds; one more request
// is taken into the operand stage, then req ready drops until the response moves.
module mips_subset_execute_unit
   import mse_pkg::*;
#(
   parameter logic [31:0] START_PC = 32'hbfc0_0000
) (
   input  logic      clock,
   input  logic      reset,
   mse_req_if.sink   req_bus,
   mse_rsp_if.source rsp_bus
);

   typedef struct packed {
      logic                  we;
      logic [REG_ADDR_W-1:0] addr;
      logic [31:0]           data;
   } rf_write_type;

   // operand stage
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_type_ff;
   logic [31:0]           s1_word_ff;
   logic [31:0]           s1_load_ff;
   logic [31:0]           rs_data_ff;
   logic [31:0]           rt_data_ff;

   // architectural state
   logic [31:0]           rf_mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0]  rf_valid_ff;
   logic [31:0]           pc_ff, pc_in;
   logic                  isolate_ff, isolate_in;
   logic [REG_ADDR_W-1:0] load_target_ff, load_target_in;
   logic                  load_wait_ff, load_wait_in;

   // response register
   logic                  out_valid_ff, out_valid_in;
   logic [31:0]           out_pc_ff;
   logic [1:0]            out_kind_ff;
   logic [31:0]           out_addr_ff;
   logic [31:0]           out_wdata_ff;
   logic [2:0]            out_status_ff;

   logic                  req_accept;
   logic                  advance;
   rf_write_type          rf_wr;
   logic                  rf_we;
   logic [REG_ADDR_W-1:0] req_rs, req_rt;

   // decoded fields of the instruction in the operand stage
   logic [5:0]            op, fn;
   logic [REG_ADDR_W-1:0] rs, rt, rd, sh;
   logic [15:0]           imm;
   logic [31:0]           simm, npc, sum, ea;
   logic [31:0]           x_pc;
   logic [1:0]            x_kind;
   logic [31:0]           x_addr, x_wdata;
   logic [2:0]            x_status;

   // handshake
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in  = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   assign req_rs = req_bus.instr_word[25:21];
   assign req_rt = req_bus.instr_word[20:16];

   // field decode
   assign op   = s1_word_ff[31:26];
   assign rs   = s1_word_ff[25:21];
   assign rt   = s1_word_ff[20:16];
   assign rd   = s1_word_ff[15:11];
   assign sh   = s1_word_ff[10:6];
   assign fn   = s1_word_ff[5:0];
   assign imm  = s1_word_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};
   assign npc  = pc_ff + 32'd4;
   assign sum  = rs_data_ff + simm;
   assign ea   = rs_data_ff + simm;

   // execute
   always_comb begin
      x_pc           = pc_ff;
      x_kind         = MEM_NONE;
      x_addr         = '0;
      x_wdata        = '0;
      x_status       = ST_DONE;
      rf_wr          = '0;
      pc_in          = pc_ff;
      isolate_in     = isolate_ff;
      load_target_in = load_target_ff;
      load_wait_in   = load_wait_ff;

      if (s1_type_ff == REQ_LOAD) begin
         // returned load data; ignored when nothing is pending
         if (load_wait_ff) begin
            rf_wr.we     = 1'b1;
            rf_wr.addr   = load_target_ff;
            rf_wr.data   = s1_load_ff;
            load_wait_in = 1'b0;
         end
      end else begin
         x_pc = npc;
         case (op)
            OP_SPECIAL: begin
               rf_wr.addr = rd;
               if (fn == FN_SLL) begin
                  rf_wr.we   = 1'b1;
                  rf_wr.data = rt_data_ff << sh;
               end else if (fn == FN_OR) begin
                  rf_wr.we   = 1'b1;
                  rf_wr.data = rs_data_ff | rt_data_ff;
               end else begin
                  x_status = ST_BAD_OP;
               end
            end
            OP_J: begin
               x_pc = (npc & JUMP_REGION_MASK) | {4'h0, s1_word_ff[25:0], 2'b00};
            end
            OP_BNE: begin
               if (rs_data_ff != rt_data_ff) begin
                  x_pc = npc + {simm[29:0], 2'b00};
               end
            end
            OP_ADDI: begin
               rf_wr.addr = rt;
               rf_wr.data = sum;
               if ((~(rs_data_ff[31] ^ simm[31]) & (rs_data_ff[31] ^ sum[31])) != 1'b0) begin
                  x_status = ST_OVERFLOW;
               end else begin
                  rf_wr.we = 1'b1;
               end
            end
            OP_ADDIU: begin
               rf_wr.we   = 1'b1;
               rf_wr.addr = rt;
               rf_wr.data = sum;
            end
            OP_LUI: begin
               rf_wr.we   = 1'b1;
               rf_wr.addr = rt;
               rf_wr.data = {imm, 16'h0000};
            end
            OP_ORI: begin
               rf_wr.we   = 1'b1;
               rf_wr.addr = rt;
               rf_wr.data = rs_data_ff | {16'h0000, imm};
            end
            OP_COP0: begin
               if (rs == COP_MT) begin
                  if (rd == COP0_STATUS) begin
                     isolate_in = rt_data_ff[ISOLATE_BIT];
                  end else begin
                     x_status = ST_BAD_COP0;
                  end
               end else begin
                  x_status = ST_BAD_OP;
               end
            end
            OP_LW: begin
               if (isolate_ff) begin
                  x_status = ST_ISOLATED;
               end else begin
                  x_kind         = MEM_READ;
                  x_addr         = ea;
                  load_target_in = rt;
                  load_wait_in   = 1'b1;
               end
            end
            OP_SW: begin
               if (isolate_ff) begin
                  x_status = ST_ISOLATED;
               end else begin
                  x_kind  = MEM_WRITE;
                  x_addr  = ea;
                  x_wdata = rt_data_ff;
               end
            end
            default: begin
               x_status = ST_BAD_OP;
            end
         endcase
         pc_in = x_pc;
      end
   end

   // register 0 is never written
   assign rf_we = advance && rf_wr.we && (rf_wr.addr != '0);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pc_ff          <= START_PC;
         isolate_ff     <= 1'b0;
         load_target_ff <= '0;
         load_wait_ff   <= 1'b0;
         rf_valid_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pc_ff          <= pc_in;
            isolate_ff     <= isolate_in;
            load_target_ff <= load_target_in;
            load_wait_ff   <= load_wait_in;
         end
         if (rf_we) begin
            rf_valid_ff[rf_wr.addr] <= 1'b1;
         end
      end
   end

   // register file write port
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem_ff[rf_wr.addr] <= rf_wr.data;
      end
   end

   // operand stage: capture request and read both operands, bypassing the write port
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff <= req_bus.req_type;
         s1_word_ff <= req_bus.instr_word;
         s1_load_ff <= req_bus.load_data;
         if (rf_we && rf_wr.addr == req_rs) begin
            rs_data_ff <= rf_wr.data;
         end else begin
            rs_data_ff <= rf_valid_ff[req_rs] ? rf_mem_ff[req_rs] : '0;
         end
         if (rf_we && rf_wr.addr == req_rt) begin
            rt_data_ff <= rf_wr.data;
         end else begin
            rt_data_ff <= rf_valid_ff[req_rt] ? rf_mem_ff[req_rt] : '0;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_pc_ff     <= x_pc;
         out_kind_ff   <= x_kind;
         out_addr_ff   <= x_addr;
         out_wdata_ff  <= x_wdata;
         out_status_ff <= x_status;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.next_pc        = out_pc_ff;
   assign rsp_bus.mem_kind       = out_kind_ff;
   assign rsp_bus.mem_address    = out_addr_ff;
   assign rsp_bus.mem_write_data = out_wdata_ff;
   assign rsp_bus.status         = out_status_ff;

`ifndef SYNTHESIS
   // request side only stalls when both stages are full and the sink is stalled
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && out_valid_ff && !rsp_bus.ready))
      else $error("request stalled without a full pipeline");

   // register 0 never gains a valid entry
   a_zero_reg: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("register 0 was written");

   // an issued LW leaves a load pending
   a_load_pending: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_type_ff == REQ_INSTR && op == OP_LW && !isolate_ff) |=> load_wait_ff)
      else $error("LW issued without pending load");

   // an isolated access never issues a memory request
   a_isolated_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == ST_ISOLATED) |-> (out_kind_ff == MEM_NONE))
      else $error("isolated access issued a memory request");
`endif

endmodule

// ===== test/tb_mips_subset_execute_unit.sv =====
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit
   import mse_pkg::*;
();

   localparam logic [31:0] START_PC = 32'hbfc0_0000;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 923;

   typedef struct packed {
      logic        req_type;
      logic [31:0] instr_word;
      logic [31:0] load_data;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  mem_kind;
      logic [31:0] mem_address;
      logic [31:0] mem_write_data;
      logic [2:0]  status;
   } rsp_beat_type;

   // directed row: payload is the instruction or the load data, by kind
   typedef struct packed {
      logic        req_type;
      logic [31:0] payload;
      logic        fixed_exp;
      logic [31:0] pc;
      logic [2:0]  st;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mse_req_if req_bus ();
   mse_rsp_if rsp_bus ();

   mips_subset_execute_unit #(.START_PC(START_PC)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // architectural state mirrored by the predictor
   logic [31:0] gpr [0:31];
   logic [31:0] cur_pc;
   logic [31:0] cop0_status;
   logic [4:0]  load_dest;
   logic        load_pending;

   rsp_beat_type rsp_awaited [$];
   dir_row_type  directed_rows [$];
   int failures = 0;
   int beats_checked = 0;
   int burst_left = 0;

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
      return {OP_SPECIAL, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] enc_mtc0(logic [4:0] rt, logic [4:0] rd);
      return enc_i(OP_COP0, COP_MT, rt, {rd, 11'd0});
   endfunction

   // low registers most of the time so results feed later instructions
   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
   endfunction

   function automatic logic [15:0] pick_imm();
      case ($urandom_range(0, 6))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'h8000;
         3: return 16'h7fff;
         4: return 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic void write_gpr(logic [4:0] idx, logic [31:0] val);
      if (idx != 5'd0) gpr[idx] = val;
   endfunction

   // one beat through the mirrored core; returns the result beat it causes
   task automatic execute_beat(input req_beat_type b, output rsp_beat_type r);
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [31:0] simm;
      logic [31:0] npc;
      logic [31:0] sum;
      logic        isolated;
      r = '0;
      r.mem_kind = MEM_NONE;
      r.status = ST_DONE;
      if (b.req_type == REQ_LOAD) begin
         if (load_pending) begin
            write_gpr(load_dest, b.load_data);
            load_pending = 1'b0;
         end
      end else begin
         op = b.instr_word[31:26];
         rs = b.instr_word[25:21];
         rt = b.instr_word[20:16];
         rd = b.instr_word[15:11];
         sh = b.instr_word[10:6];
         fn = b.instr_word[5:0];
         simm = {{16{b.instr_word[15]}}, b.instr_word[15:0]};
         npc = cur_pc + 32'd4;
         isolated = cop0_status[ISOLATE_BIT];
         case (op)
            OP_SPECIAL: begin
               if (fn == FN_SLL) write_gpr(rd, gpr[rt] << sh);
               else if (fn == FN_OR) write_gpr(rd, gpr[rs] | gpr[rt]);
               else r.status = ST_BAD_OP;
            end
            OP_J: npc = (npc & JUMP_REGION_MASK) | {4'h0, b.instr_word[25:0], 2'b00};
            OP_BNE: begin
               if (gpr[rs] != gpr[rt]) npc = npc + (simm << 2);
            end
            OP_ADDI: begin
               sum = gpr[rs] + simm;
               // signed overflow: same operand signs, different result sign
               if (gpr[rs][31] == simm[31] && sum[31] != simm[31]) r.status = ST_OVERFLOW;
               else write_gpr(rt, sum);
            end
            OP_ADDIU: write_gpr(rt, gpr[rs] + simm);
            OP_LUI: write_gpr(rt, {b.instr_word[15:0], 16'h0000});
            OP_ORI: write_gpr(rt, gpr[rs] | {16'h0000, b.instr_word[15:0]});
            OP_COP0: begin
               if (rs != COP_MT) r.status = ST_BAD_OP;
               else if (rd == COP0_STATUS) cop0_status = gpr[rt];
               else r.status = ST_BAD_COP0;
            end
            OP_LW: begin
               if (isolated) begin
                  r.status = ST_ISOLATED;
               end else begin
                  r.mem_kind = MEM_READ;
                  r.mem_address = gpr[rs] + simm;
                  load_dest = rt;
                  load_pending = 1'b1;
               end
            end
            OP_SW: begin
               if (isolated) begin
                  r.status = ST_ISOLATED;
               end else begin
                  r.mem_kind = MEM_WRITE;
                  r.mem_address = gpr[rs] + simm;
                  r.mem_write_data = gpr[rt];
               end
            end
            default: r.status = ST_BAD_OP;
         endcase
         cur_pc = npc;
      end
      r.next_pc = cur_pc;
   endtask

   task automatic add_row(logic kind, logic [31:0] payload, logic fixed_exp,
                          logic [31:0] pc, logic [2:0] st);
      dir_row_type row;
      row.req_type = kind;
      row.payload = payload;
      row.fixed_exp = fixed_exp;
      row.pc = pc;
      row.st = st;
      directed_rows.push_back(row);
   endtask

   // random beat, mostly well-formed instructions with loads answered
   function automatic req_beat_type next_random_beat(output bit ignored);
      req_beat_type b;
      int           sel;
      logic [4:0]   rs;
      logic [4:0]   rt;
      logic [4:0]   rd;
      logic [5:0]   fn;
      b.req_type = REQ_INSTR;
      b.instr_word = $urandom;
      b.load_data = $urandom;
      ignored = 1'b0;
      rs = pick_reg();
      rt = pick_reg();
      rd = pick_reg();
      sel = $urandom_range(0, 99);
      if (load_pending && sel < 35) begin
         b.req_type = REQ_LOAD;
         b.load_data = pick_word();
         return b;
      end
      if (!load_pending && sel < 3) begin
         b.req_type = REQ_LOAD;
         ignored = 1'b1;
         return b;
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         b.instr_word = enc_r(rs, rt, rd, 5'($urandom), FN_SLL);
      end else if (sel < 20) begin
         b.instr_word = enc_r(rs, rt, rd, 5'($urandom), FN_OR);
      end else if (sel < 25) begin
         b.instr_word = {OP_J, 26'($urandom)};
      end else if (sel < 35) begin
         b.instr_word = enc_i(OP_BNE, rs, rt, pick_imm());
      end else if (sel < 45) begin
         b.instr_word = enc_i(OP_ADDI, rs, rt, pick_imm());
      end else if (sel < 53) begin
         b.instr_word = enc_i(OP_ADDIU, rs, rt, pick_imm());
      end else if (sel < 60) begin
         b.instr_word = enc_i(OP_LUI, rs, rt, pick_imm());
      end else if (sel < 68) begin
         b.instr_word = enc_i(OP_ORI, rs, rt, pick_imm());
      end else if (sel < 71) begin
         // mostly clear isolation again so loads and stores get through
         if (cop0_status[ISOLATE_BIT] && $urandom_range(0, 9) < 7) rt = 5'd0;
         b.instr_word = enc_mtc0(rt, COP0_STATUS);
      end else if (sel < 72) begin
         if (rd == COP0_STATUS) rd = 5'd13;
         b.instr_word = enc_i(OP_COP0, COP_MT, rt, {rd, 11'($urandom)});
      end else if (sel < 73) begin
         if (rs == COP_MT) rs = 5'd0;
         b.instr_word = enc_i(OP_COP0, rs, rt, 16'($urandom));
      end else if (sel < 85) begin
         b.instr_word = enc_i(OP_LW, rs, rt, pick_imm());
      end else if (sel < 95) begin
         b.instr_word = enc_i(OP_SW, rs, rt, pick_imm());
      end else if (sel < 98) begin
         fn = 6'($urandom);
         if (fn == FN_SLL || fn == FN_OR) fn = 6'h3f;
         b.instr_word = enc_r(rs, rt, rd, 5'($urandom), fn);
      end
      return b;
   endfunction

   // offer one beat, predict it once taken, then maybe open a gap
   task automatic push_beat(input req_beat_type b, input logic fixed_exp,
                            input rsp_beat_type fixed);
      rsp_beat_type predicted;
      req_bus.valid <= 1'b1;
      req_bus.req_type <= b.req_type;
      req_bus.instr_word <= b.instr_word;
      req_bus.load_data <= b.load_data;
      do @(posedge clock); while (!req_bus.ready);
      execute_beat(b, predicted);
      rsp_awaited.push_back(fixed_exp ? fixed : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
      end
   endtask

   // stimulus
   initial begin
      req_beat_type b;
      rsp_beat_type fixed;
      dir_row_type  row;
      bit           ignored;
      int           taken;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= REQ_INSTR;
      req_bus.instr_word <= '0;
      req_bus.load_data <= '0;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      cur_pc = START_PC;
      cop0_status = '0;
      load_dest = '0;
      load_pending = 1'b0;

      add_row(REQ_LOAD, 32'hffff_ffff, 1'b1, START_PC, ST_DONE);
      add_row(REQ_INSTR, 32'hffff_ffff, 1'b1, START_PC + 32'd4, ST_BAD_OP);
      add_row(REQ_INSTR, enc_r(5'd31, 5'd31, 5'd31, 5'd31, 6'h3f), 1'b1,
              START_PC + 32'd8, ST_BAD_OP);
      add_row(REQ_INSTR, enc_i(OP_COP0, 5'd0, 5'd1, {COP0_STATUS, 11'd0}), 1'b1,
              START_PC + 32'd12, ST_BAD_OP);
      add_row(REQ_INSTR, enc_mtc0(5'd0, 5'd13), 1'b1, START_PC + 32'd16, ST_BAD_COP0);
      add_row(REQ_INSTR, enc_i(OP_LUI, 5'd0, 5'd1, 16'h7fff), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_ORI, 5'd1, 5'd1, 16'hffff), 1'b0, '0, ST_DONE);
      // r1 is the largest positive word: both ADDI boundary cases overflow
      add_row(REQ_INSTR, enc_i(OP_ADDI, 5'd1, 5'd2, 16'h0001), 1'b1,
              START_PC + 32'd28, ST_OVERFLOW);
      add_row(REQ_INSTR, enc_i(OP_ADDIU, 5'd1, 5'd2, 16'h0001), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_ADDI, 5'd2, 5'd3, 16'hffff), 1'b1,
              START_PC + 32'd36, ST_OVERFLOW);
      add_row(REQ_INSTR, enc_r(5'd0, 5'd1, 5'd4, 5'd31, FN_SLL), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_r(5'd1, 5'd2, 5'd5, 5'd0, FN_OR), 1'b0, '0, ST_DONE);
      // all ones into status isolates the cache
      add_row(REQ_INSTR, enc_mtc0(5'd5, COP0_STATUS), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_LW, 5'd5, 5'd6, 16'h0000), 1'b1,
              START_PC + 32'd52, ST_ISOLATED);
      add_row(REQ_INSTR, enc_i(OP_SW, 5'd5, 5'd5, 16'h0000), 1'b1,
              START_PC + 32'd56, ST_ISOLATED);
      add_row(REQ_INSTR, enc_mtc0(5'd0, COP0_STATUS), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_SW, 5'd5, 5'd5, 16'h8000), 1'b0, '0, ST_DONE);
      // load left pending across an unrelated instruction
      add_row(REQ_INSTR, enc_i(OP_LW, 5'd5, 5'd6, 16'h7fff), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_LUI, 5'd0, 5'd7, 16'hffff), 1'b0, '0, ST_DONE);
      add_row(REQ_LOAD, 32'hffff_ffff, 1'b0, '0, ST_DONE);
      // load into r0 is issued, its data dropped
      add_row(REQ_INSTR, enc_i(OP_LW, 5'd6, 5'd0, 16'h0000), 1'b0, '0, ST_DONE);
      add_row(REQ_LOAD, 32'h5a5a_5a5a, 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_BNE, 5'd6, 5'd0, 16'h8000), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_BNE, 5'd0, 5'd0, 16'h7fff), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, {OP_J, 26'h3ff_ffff}, 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_BNE, 5'd6, 5'd0, 16'h7fff), 1'b0, '0, ST_DONE);
      add_row(REQ_INSTR, enc_i(OP_ADDI, 5'd6, 5'd8, 16'h8000), 1'b0, '0, ST_DONE);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         b.req_type = row.req_type;
         b.instr_word = (row.req_type == REQ_INSTR) ? row.payload : 32'h0;
         b.load_data = (row.req_type == REQ_LOAD) ? row.payload : 32'h0;
         fixed = '0;
         fixed.next_pc = row.pc;
         fixed.mem_kind = MEM_NONE;
         fixed.status = row.st;
         push_beat(b, row.fixed_exp, fixed);
      end

      // random part, with one full drain in the middle
      taken = 0;
      while (taken < RANDOM_ITEMS) begin
         if (taken == 400) begin
            req_bus.valid <= 1'b0;
            while (rsp_awaited.size() != 0) @(posedge clock);
            taken++;
         end
         b = next_random_beat(ignored);
         push_beat(b, 1'b0, '0);
         if (!ignored) taken++;
      end
      req_bus.valid <= 1'b0;

      while (rsp_awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // result receiver: changing stall modes, plus one long hold-off
   initial begin
      int  mode;
      int  phase_left;
      int  tick;
      bit  long_hold_done;
      rsp_bus.ready <= 1'b0;
      mode = 0;
      phase_left = 0;
      tick = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (!long_hold_done && beats_checked >= 200) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (120) @(posedge clock);
         end else begin
            if (phase_left == 0) begin
               mode = $urandom_range(0, 3);
               phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               default: rsp_bus.ready <= (tick % 4 != 3);
            endcase
         end
      end
   end

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_checked++;
         if (rsp_awaited.size() == 0) begin
            $error("result beat arrived with nothing outstanding");
            failures++;
         end else begin
            want = rsp_awaited.pop_front();
            compare_field("next_pc", want.next_pc, rsp_bus.next_pc);
            compare_field("mem_kind", 32'(want.mem_kind), 32'(rsp_bus.mem_kind));
            compare_field("mem_address", want.mem_address, rsp_bus.mem_address);
            compare_field("mem_write_data", want.mem_write_data, rsp_bus.mem_write_data);
            compare_field("status", 32'(want.status), 32'(rsp_bus.status));
         end
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      int idle_cycles;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

// ===== mips_subset_execute_unit.f =====
rtl/mse_pkg.sv
rtl/mse_req_if.sv
rtl/mse_rsp_if.sv
rtl/mips_subset_execute_unit.sv
test/tb_mips_subset_execute_unit.sv
